// ===== hw/rtl/tcse_pkg.sv =====
// Package for the TCP connection segment engine: flags, phases, codes.
// No dependencies.
`default_nettype none
package tcse_pkg;
  localparam int unsigned MaxConnDefault = 16;
  localparam logic [15:0] MssReset = 16'd1460;

  localparam logic [8:0] FlFin = 9'h001;
  localparam logic [8:0] FlSyn = 9'h002;
  localparam logic [8:0] FlPsh = 9'h008;
  localparam logic [8:0] FlAck = 9'h010;

  localparam logic [1:0] PhClosed  = 2'd0;
  localparam logic [1:0] PhSynSent = 2'd1;
  localparam logic [1:0] PhEstab   = 2'd2;
  localparam logic [1:0] PhClosing = 2'd3;

  localparam logic [1:0] ReqSeg   = 2'd0;
  localparam logic [1:0] ReqOpen  = 2'd1;
  localparam logic [1:0] ReqClose = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StNoConn  = 2'd2;

  // Result of a table search, handed from the search unit to the sequencer.
  typedef struct packed {
    logic       done;
    logic       hit;
  } search_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tcse_search.sv =====
// Sequential key search over the connection table, one entry per cycle.
// Depends on tcse_pkg.
`default_nettype none
module tcse_search #(
  parameter int unsigned MaxConn = tcse_pkg::MaxConnDefault,
  parameter int unsigned IdxW = (MaxConn > 1) ? $clog2(MaxConn) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            go_i,
  input  wire logic [31:0]     rd_key_i,
  input  wire logic            rd_valid_i,
  input  wire logic [31:0]     key_i,
  output logic [IdxW-1:0]      idx_o,
  output tcse_pkg::search_t    res_o
);
  logic [IdxW:0] cnt_q, cnt_d;
  logic          act_q, act_d;
  tcse_pkg::search_t res_d, res_q;

  // Walk the table; the caller reads the entry at idx_o each cycle.
  always_comb begin
    cnt_d = cnt_q;
    act_d = act_q;
    res_d = '0;
    if (go_i) begin
      cnt_d = '0;
      act_d = 1'b1;
    end else if (act_q) begin
      if (rd_valid_i && rd_key_i == key_i) begin
        res_d = '{done: 1'b1, hit: 1'b1};
        act_d = 1'b0;
      end else if (cnt_q == (IdxW+1)'(MaxConn - 1)) begin
        res_d = '{done: 1'b1, hit: 1'b0};
        act_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      act_q <= 1'b0;
      res_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      act_q <= act_d;
      res_q <= res_d;
    end
  end

  assign idx_o = cnt_q[IdxW-1:0];
  assign res_o = res_q;
endmodule
`default_nettype wire

// ===== hw/rtl/tcp_connection_segment_engine_core.sv =====
// Top level of the TCP connection segment engine: sequencer and table.
// Depends on tcse_pkg and tcse_search.
//
// channel   direction  handshake         payload
// request   in         start & !busy     req_type_i .. segment_len_i
// result    out        done_o strobe     send_o .. status_o
// config    in         cfg_valid_i/ready cfg_data_i (advertised_mss)
//
// From acceptance to the edge that takes its result, an item passes through a
// search step per table entry compared, a step that registers the search
// result, an update step, and the strobe cycle. busy is high from acceptance
// until the strobe cycle, in which a new word may be taken. Reset clears the
// valid bits and the fill count at once. The receiver cannot stall.
`default_nettype none
module tcp_connection_segment_engine_core #(
  parameter int unsigned MaxConn = tcse_pkg::MaxConnDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [15:0] local_port_i,
  input  wire logic [15:0] remote_port_i,
  input  wire logic [31:0] remote_ip_i,
  input  wire logic [31:0] seq_num_i,
  input  wire logic [31:0] ack_num_i,
  input  wire logic [8:0]  seg_flags_i,
  input  wire logic [15:0] segment_len_i,
  output logic             done_o,
  output logic             send_o,
  output logic [8:0]       out_flags_o,
  output logic [31:0]      out_seq_o,
  output logic [31:0]      out_ack_o,
  output logic [15:0]      out_local_port_o,
  output logic [15:0]      out_remote_port_o,
  output logic [31:0]      out_remote_ip_o,
  output logic [2:0]       out_header_words_o,
  output logic             deliver_o,
  output logic [3:0]       conn_index_o,
  output logic [1:0]       conn_phase_out_o,
  output logic [1:0]       status_o
);
  localparam int unsigned IdxW = (MaxConn > 1) ? $clog2(MaxConn) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_UPDATE} state_e;

  // Connection table.
  logic [MaxConn-1:0] valid_q;
  logic [31:0] ports_q [MaxConn];
  logic [31:0] ip_q    [MaxConn];
  logic [31:0] seq_q   [MaxConn];
  logic [31:0] ack_q   [MaxConn];
  logic [1:0]  phase_q [MaxConn];
  logic [IdxW:0] fill_q;
  logic [15:0] mss_q;

  state_e state_q;
  logic [1:0]  req_q;
  logic [31:0] key_q, ip_in_q, seq_in_q, ack_in_q;
  logic [8:0]  flags_q;
  logic [15:0] len_q;

  logic [IdxW-1:0] sidx;
  tcse_pkg::search_t sres;
  logic go;

  assign go = start && !busy;
  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  tcse_search #(.MaxConn(MaxConn), .IdxW(IdxW)) u_search (
    .clk_i, .rst_ni, .go_i(go),
    .rd_key_i(ports_q[sidx]), .rd_valid_i(valid_q[sidx]),
    .key_i(key_q), .idx_o(sidx), .res_o(sres)
  );

  // Found index is latched by the search unit's counter.
  logic [IdxW-1:0] hit_idx_q;
  always_ff @(posedge clk_i) hit_idx_q <= sidx;

  // The search result lasts one cycle; hold the hit flag for the update step.
  logic hit_seen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hit_seen_q <= 1'b0;
    else if (sres.done) hit_seen_q <= sres.hit;
  end

  // Decision logic for the update step.
  logic            full, use_entry, alloc;
  logic [IdxW-1:0] e;
  logic [31:0]     new_ack, r_seq, r_ack, r_ip, r_ports;
  logic [1:0]      r_phase, cur_phase;
  logic            r_send, r_deliver;
  logic [8:0]      r_flags;
  logic [1:0]      r_status;
  always_comb begin
    full      = fill_q == (IdxW+1)'(MaxConn);
    alloc     = 1'b0;
    use_entry = 1'b0;
    e         = hit_seen_q ? hit_idx_q : fill_q[IdxW-1:0];
    r_status  = tcse_pkg::StOk;
    unique case (req_q)
      tcse_pkg::ReqSeg, tcse_pkg::ReqOpen: begin
        if (hit_seen_q) use_entry = 1'b1;
        else if (full) r_status = tcse_pkg::StFull;
        else begin
          alloc = 1'b1;
          use_entry = 1'b1;
        end
      end
      tcse_pkg::ReqClose: begin
        if (hit_seen_q) use_entry = 1'b1;
        else r_status = tcse_pkg::StNoConn;
      end
      default: ;
    endcase
    r_ports   = alloc ? key_q : ports_q[e];
    r_ip      = alloc ? ip_in_q : ip_q[e];
    r_seq     = alloc ? 32'd0 : seq_q[e];
    r_ack     = alloc ? 32'd0 : ack_q[e];
    cur_phase = alloc ? tcse_pkg::PhClosed : phase_q[e];
    r_phase   = cur_phase;
    r_send    = 1'b0;
    r_deliver = 1'b0;
    r_flags   = '0;
    new_ack   = seq_in_q + ((len_q == 16'd0 || (flags_q & tcse_pkg::FlSyn) != '0)
                ? 32'd1 : {16'd0, len_q});
    unique case (req_q)
      tcse_pkg::ReqSeg: begin
        r_seq = ack_in_q;
        r_ack = new_ack;
        priority if (flags_q[1] && flags_q[4]) begin
          r_phase = tcse_pkg::PhEstab;
          r_send = 1'b1; r_flags = tcse_pkg::FlAck;
        end else if (flags_q[3] && flags_q[4]) begin
          r_deliver = 1'b1;
          r_send = 1'b1; r_flags = tcse_pkg::FlAck;
        end else if (flags_q[0] && flags_q[4]) begin
          r_flags = (cur_phase == tcse_pkg::PhEstab) ?
                    (tcse_pkg::FlFin | tcse_pkg::FlAck) : tcse_pkg::FlAck;
          r_send = 1'b1;
          r_phase = tcse_pkg::PhClosed;
        end else if (flags_q[1]) begin
          r_phase = tcse_pkg::PhEstab;
          r_send = 1'b1; r_flags = tcse_pkg::FlSyn | tcse_pkg::FlAck;
        end else begin
        end
      end
      tcse_pkg::ReqOpen: begin
        r_phase = tcse_pkg::PhSynSent;
        r_send = 1'b1; r_flags = tcse_pkg::FlSyn;
      end
      tcse_pkg::ReqClose: begin
        r_phase = tcse_pkg::PhClosing;
        r_send = 1'b1; r_flags = tcse_pkg::FlFin | tcse_pkg::FlAck;
      end
      default: ;
    endcase
  end

  // Sequencer, table control state and the done strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      fill_q  <= '0;
      mss_q   <= tcse_pkg::MssReset;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (cfg_valid_i) mss_q <= cfg_data_i;
      unique case (state_q)
        S_IDLE: if (go) state_q <= S_SEARCH;
        S_SEARCH: if (sres.done) state_q <= S_UPDATE;
        S_UPDATE: begin
          state_q <= S_IDLE;
          done_o  <= 1'b1;
          if (alloc) begin
            valid_q[e] <= 1'b1;
            fill_q <= fill_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers: request capture, table entries, result fields.
  always_ff @(posedge clk_i) begin
    if (go) begin
      req_q <= req_type_i;
      key_q <= {local_port_i, remote_port_i};
      ip_in_q <= remote_ip_i;
      seq_in_q <= seq_num_i;
      ack_in_q <= ack_num_i;
      flags_q <= seg_flags_i;
      len_q <= segment_len_i;
    end
    if (state_q == S_UPDATE) begin
      if (use_entry) begin
        ports_q[e] <= r_ports;
        ip_q[e]    <= r_ip;
        seq_q[e]   <= r_seq;
        ack_q[e]   <= r_ack;
        phase_q[e] <= r_phase;
      end
      send_o             <= use_entry & r_send;
      out_flags_o        <= use_entry ? r_flags : 9'd0;
      out_seq_o          <= use_entry ? r_seq : 32'd0;
      out_ack_o          <= use_entry ? r_ack : 32'd0;
      out_local_port_o   <= use_entry ? r_ports[31:16] : 16'd0;
      out_remote_port_o  <= use_entry ? r_ports[15:0] : 16'd0;
      out_remote_ip_o    <= use_entry ? r_ip : 32'd0;
      out_header_words_o <= (use_entry && r_flags[1]) ? 3'd6 : 3'd5;
      deliver_o          <= use_entry & r_deliver;
      conn_index_o       <= use_entry ? 4'(e) : 4'd0;
      conn_phase_out_o   <= use_entry ? r_phase : 2'd0;
      status_o           <= r_status;
    end
  end
endmodule
`default_nettype wire

// ===== bench/tcp_connection_segment_engine_core_tb.sv =====
// Self-checking testbench for the TCP connection segment engine core.
// Uses tcse_pkg for flag, phase, request and status codes; needs only the RTL.
`timescale 1ns / 100ps

module tcp_connection_segment_engine_core_tb;
  import tcse_pkg::*;

  localparam int unsigned NumConn   = 16;
  localparam int unsigned CycleCap  = 400000;
  localparam int unsigned Drain     = 40;
  localparam int unsigned NumRandom = 630;
  localparam int unsigned PoolSize  = 13;

  // One request word and one reply word, field for field.
  typedef struct {
    logic [1:0]  req;
    logic [15:0] lport;
    logic [15:0] rport;
    logic [31:0] rip;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [8:0]  flags;
    logic [15:0] len;
  } seg_req_t;

  typedef struct {
    logic        send;
    logic [8:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] lport;
    logic [15:0] rport;
    logic [31:0] rip;
    logic [2:0]  hdr_words;
    logic        deliver;
    logic [3:0]  idx;
    logic [1:0]  phase;
    logic [1:0]  status;
  } reply_t;

  // A directed row: the request and, where typed in, the reply it must give.
  typedef struct {
    seg_req_t rq;
    bit       typed;
    reply_t   rsp;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic [1:0]  req_type_i = '0;
  logic [15:0] local_port_i = '0;
  logic [15:0] remote_port_i = '0;
  logic [31:0] remote_ip_i = '0;
  logic [31:0] seq_num_i = '0;
  logic [31:0] ack_num_i = '0;
  logic [8:0]  seg_flags_i = '0;
  logic [15:0] segment_len_i = '0;
  logic        done_o;
  logic        send_o;
  logic [8:0]  out_flags_o;
  logic [31:0] out_seq_o;
  logic [31:0] out_ack_o;
  logic [15:0] out_local_port_o;
  logic [15:0] out_remote_port_o;
  logic [31:0] out_remote_ip_o;
  logic [2:0]  out_header_words_o;
  logic        deliver_o;
  logic [3:0]  conn_index_o;
  logic [1:0]  conn_phase_out_o;
  logic [1:0]  status_o;

  tcp_connection_segment_engine_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .req_type_i(req_type_i), .local_port_i(local_port_i),
    .remote_port_i(remote_port_i), .remote_ip_i(remote_ip_i),
    .seq_num_i(seq_num_i), .ack_num_i(ack_num_i), .seg_flags_i(seg_flags_i),
    .segment_len_i(segment_len_i), .done_o(done_o), .send_o(send_o),
    .out_flags_o(out_flags_o), .out_seq_o(out_seq_o), .out_ack_o(out_ack_o),
    .out_local_port_o(out_local_port_o), .out_remote_port_o(out_remote_port_o),
    .out_remote_ip_o(out_remote_ip_o), .out_header_words_o(out_header_words_o),
    .deliver_o(deliver_o), .conn_index_o(conn_index_o),
    .conn_phase_out_o(conn_phase_out_o), .status_o(status_o)
  );

  // Clock with 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow connection table kept by the testbench.
  logic        conn_used [NumConn];
  logic [31:0] conn_key [NumConn];
  logic [31:0] conn_ip [NumConn];
  logic [31:0] conn_seq [NumConn];
  logic [31:0] conn_ack [NumConn];
  logic [1:0]  conn_phase [NumConn];
  int unsigned conn_fill;
  logic [15:0] mss_shadow;

  reply_t      pending_replies[$];
  int unsigned mismatches;
  int unsigned cycles;

  function automatic int find_conn(logic [31:0] key);
    for (int i = 0; i < NumConn; i++) begin
      if (conn_used[i] && conn_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Finds the connection, or claims the next free entry; -1 when full.
  function automatic int claim_conn(logic [31:0] key, logic [31:0] ip);
    int e;
    e = find_conn(key);
    if (e < 0 && conn_fill < NumConn) begin
      e = conn_fill;
      conn_used[e] = 1'b1;
      conn_key[e] = key;
      conn_ip[e] = ip;
      conn_seq[e] = '0;
      conn_ack[e] = '0;
      conn_phase[e] = PhClosed;
      conn_fill++;
    end
    return e;
  endfunction

  // Applies one request to the shadow table and returns the reply it causes.
  function automatic reply_t predict_reply(seg_req_t r);
    reply_t o;
    int e;
    logic [31:0] key;
    logic [8:0] of;
    logic snd, dlv;
    logic [1:0] st;
    o = '{default: '0};
    o.hdr_words = 3'd5;
    key = {r.lport, r.rport};
    e = -1;
    of = '0;
    snd = 1'b0;
    dlv = 1'b0;
    st = StOk;
    if (r.req == ReqSeg) begin
      e = claim_conn(key, r.rip);
      if (e < 0) begin
        st = StFull;
      end else begin
        conn_seq[e] = r.ack;
        conn_ack[e] = r.seq + ((r.len == 0 || (r.flags & FlSyn) != 0) ? 32'd1 : 32'(r.len));
        if ((r.flags & (FlAck | FlSyn)) == (FlAck | FlSyn)) begin
          conn_phase[e] = PhEstab;
          snd = 1'b1;
          of = FlAck;
        end else if ((r.flags & (FlAck | FlPsh)) == (FlAck | FlPsh)) begin
          dlv = 1'b1;
          snd = 1'b1;
          of = FlAck;
        end else if ((r.flags & (FlAck | FlFin)) == (FlAck | FlFin)) begin
          of = (conn_phase[e] == PhEstab) ? (FlFin | FlAck) : FlAck;
          snd = 1'b1;
          conn_phase[e] = PhClosed;
        end else if ((r.flags & FlSyn) != 0) begin
          conn_phase[e] = PhEstab;
          snd = 1'b1;
          of = FlSyn | FlAck;
        end
      end
    end else if (r.req == ReqOpen) begin
      e = claim_conn(key, r.rip);
      if (e < 0) begin
        st = StFull;
      end else begin
        conn_phase[e] = PhSynSent;
        snd = 1'b1;
        of = FlSyn;
      end
    end else if (r.req == ReqClose) begin
      e = find_conn(key);
      if (e < 0) begin
        st = StNoConn;
      end else begin
        conn_phase[e] = PhClosing;
        snd = 1'b1;
        of = FlFin | FlAck;
      end
    end
    if (e >= 0) begin
      o.send = snd;
      o.flags = of;
      o.seq = conn_seq[e];
      o.ack = conn_ack[e];
      o.lport = conn_key[e][31:16];
      o.rport = conn_key[e][15:0];
      o.rip = conn_ip[e];
      o.hdr_words = ((of & FlSyn) != 0) ? 3'd6 : 3'd5;
      o.deliver = dlv;
      o.idx = 4'(e);
      o.phase = conn_phase[e];
    end
    o.status = st;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Every reply strobe is checked against the oldest pending reply.
  always @(posedge clk_i) begin
    reply_t w;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with nothing pending", 32'd0, 32'd0);
      end else begin
        w = pending_replies.pop_front();
        check_field("send", send_o, w.send);
        check_field("out_flags", out_flags_o, w.flags);
        check_field("out_seq", out_seq_o, w.seq);
        check_field("out_ack", out_ack_o, w.ack);
        check_field("out_local_port", out_local_port_o, w.lport);
        check_field("out_remote_port", out_remote_port_o, w.rport);
        check_field("out_remote_ip", out_remote_ip_o, w.rip);
        check_field("out_header_words", out_header_words_o, w.hdr_words);
        check_field("deliver", deliver_o, w.deliver);
        check_field("conn_index", conn_index_o, w.idx);
        check_field("conn_phase_out", conn_phase_out_o, w.phase);
        check_field("status", status_o, w.status);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("tcp_connection_segment_engine_core verification failed");
      $finish;
    end
  end

  // Holds start low for the given gap, then presents the word until it is taken.
  task automatic issue_word(seg_req_t r, int unsigned gap, bit typed, reply_t rsp);
    reply_t p;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= r.req;
    local_port_i <= r.lport;
    remote_port_i <= r.rport;
    remote_ip_i <= r.rip;
    seq_num_i <= r.seq;
    ack_num_i <= r.ack;
    seg_flags_i <= r.flags;
    segment_len_i <= r.len;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    p = predict_reply(r);
    pending_replies.push_back(typed ? rsp : p);
  endtask

  // Waits for every pending reply plus settle time, then writes the MSS.
  task automatic write_mss(logic [15:0] v);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    mss_shadow = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic seg_req_t mk_req(logic [1:0] rq, logic [15:0] lp, logic [15:0] rp,
                                      logic [31:0] ip, logic [31:0] sq, logic [31:0] ak,
                                      logic [8:0] fl, logic [15:0] ln);
    seg_req_t r;
    r = '{req: rq, lport: lp, rport: rp, rip: ip, seq: sq, ack: ak, flags: fl, len: ln};
    return r;
  endfunction

  stim_row_t   rows[$];
  logic [15:0] pool_l [PoolSize];
  logic [15:0] pool_r [PoolSize];

  initial begin
    reply_t none;
    reply_t rsp;
    seg_req_t r;
    stim_row_t row;
    int unsigned k, pick, gap;
    bit no_idle;

    mismatches = 0;
    cycles = 0;
    conn_fill = 0;
    mss_shadow = MssReset;
    foreach (conn_used[i]) conn_used[i] = 1'b0;
    none = '{default: '0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mss(16'hFFFF);

    // Directed table. Typed replies: a first open, a close with no
    // connection, and an unknown request.
    rsp = '{send: 1'b1, flags: FlSyn, seq: 32'd0, ack: 32'd0, lport: 16'h0000,
            rport: 16'hFFFF, rip: 32'hFFFF_FFFF, hdr_words: 3'd6, deliver: 1'b0,
            idx: 4'd0, phase: PhSynSent, status: StOk};
    rows.push_back('{mk_req(ReqOpen, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd0,
                            9'd0, 16'd0), 1'b1, rsp});
    rows.push_back('{mk_req(ReqSeg, 16'h0000, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'd0,
                            FlSyn | FlAck, 16'd0), 1'b0, none});
    rows.push_back('{mk_req(ReqSeg, 16'h0000, 16'hFFFF, 32'd0, 32'h1234_5678,
                            32'hFFFF_FFFF, FlPsh | FlAck, 16'd65515), 1'b0, none});
    rows.push_back('{mk_req(ReqSeg, 16'h0000, 16'hFFFF, 32'd0, 32'd7, 32'd9,
                            FlFin | FlAck, 16'd0), 1'b0, none});
    rows.push_back('{mk_req(ReqSeg, 16'h0000, 16'hFFFF, 32'd0, 32'd8, 32'd10,
                            FlFin | FlAck, 16'd0), 1'b0, none});
    rows.push_back('{mk_req(ReqSeg, 16'hFFFF, 16'h0000, 32'd0, 32'h8000_0000,
                            32'h0000_0001, FlSyn, 16'd100), 1'b0, none});
    rows.push_back('{mk_req(ReqSeg, 16'hFFFF, 16'h0000, 32'h5555_AAAA, 32'd1, 32'd2,
                            9'h1FF, 16'd1), 1'b0, none});
    rows.push_back('{mk_req(ReqSeg, 16'hFFFF, 16'h0000, 32'd0, 32'd3, 32'd4,
                            9'h1E4, 16'd20), 1'b0, none});
    rows.push_back('{mk_req(ReqSeg, 16'hFFFF, 16'h0000, 32'd0, 32'd5, 32'd6,
                            9'd0, 16'd0), 1'b0, none});
    rows.push_back('{mk_req(ReqClose, 16'hFFFF, 16'h0000, 32'd0, 32'd0, 32'd0,
                            9'd0, 16'd0), 1'b0, none});
    rsp = '{default: '0};
    rsp.hdr_words = 3'd5;
    rsp.status = StNoConn;
    rows.push_back('{mk_req(ReqClose, 16'h1234, 16'h4321, 32'd0, 32'd0, 32'd0,
                            9'd0, 16'd0), 1'b1, rsp});
    rsp.status = StOk;
    rows.push_back('{mk_req(2'd3, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 32'd1, 32'd1,
                            FlSyn, 16'd1), 1'b1, rsp});
    rows.push_back('{mk_req(ReqOpen, 16'hFFFF, 16'h0000, 32'h0BAD_F00D, 32'd0, 32'd0,
                            9'd0, 16'd0), 1'b0, none});
    rows.push_back('{mk_req(ReqSeg, 16'hFFFF, 16'h0000, 32'd0, 32'hFFFF_FFF0, 32'd11,
                            FlAck, 16'h0020), 1'b0, none});
    rows.push_back('{mk_req(ReqSeg, 16'hFFFF, 16'h0000, 32'd0, 32'd12, 32'd13,
                            FlPsh, 16'd5), 1'b0, none});
    rows.push_back('{mk_req(ReqSeg, 16'h0000, 16'hFFFF, 32'd0, 32'd14, 32'd15,
                            FlFin, 16'd0), 1'b0, none});
    foreach (rows[i]) begin
      row = rows[i];
      issue_word(row.rq, $urandom_range(0, 18), row.typed, row.rsp);
    end

    write_mss(16'h0000);

    // Connection pool: most traffic reuses these keys; noise fills the rest.
    for (int i = 0; i < PoolSize; i++) begin
      pool_l[i] = 16'($urandom);
      pool_r[i] = 16'($urandom);
    end

    // Random part: well-formed traffic on the pool with random content,
    // plus noise words with random keys and flags.
    for (k = 0; k < NumRandom; k++) begin
      if (k == NumRandom / 2) write_mss(16'($urandom));
      no_idle = ((k / 50) % 3) == 0;
      pick = $urandom_range(0, 99);
      r.rip = $urandom;
      r.seq = $urandom;
      r.ack = $urandom;
      r.len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65515))
                                          : 16'($urandom_range(0, 1460));
      if (pick < 80) begin
        r.lport = pool_l[$urandom_range(0, PoolSize - 1)];
        r.rport = pool_r[$urandom_range(0, PoolSize - 1)];
        if ($urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, PoolSize - 1);
          r.lport = pool_l[pick];
          r.rport = pool_r[pick];
        end
        pick = $urandom_range(0, 99);
        r.req = (pick < 70) ? ReqSeg : (pick < 85) ? ReqOpen : ReqClose;
        case ($urandom_range(0, 5))
          0: r.flags = FlSyn;
          1: r.flags = FlSyn | FlAck;
          2: r.flags = FlPsh | FlAck;
          3: r.flags = FlFin | FlAck;
          4: r.flags = FlAck;
          default: r.flags = 9'($urandom);
        endcase
        if ($urandom_range(0, 4) == 0) r.flags = r.flags | (9'($urandom) & 9'h1E4);
      end else begin
        r.lport = 16'($urandom);
        r.rport = 16'($urandom);
        r.req = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 30) == 0) r.req = 2'd3;
        r.flags = 9'($urandom);
      end
      gap = no_idle ? 0 : $urandom_range(0, 18);
      issue_word(r, gap, 1'b0, none);
    end

    write_mss(MssReset);

    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("tcp_connection_segment_engine_core verification clean");
    end else begin
      $display("tcp_connection_segment_engine_core verification failed");
    end
    $finish;
  end

endmodule
